>>> sv/spbd_pkg.sv
// Shared constants for the solar panel boxcar dashboard.
package spbd_pkg;

	// Fixed field widths
	localparam int SHOWN_W     = 16;
	localparam int POWER_W     = 20;
	localparam int THEO_W      = 20;
	localparam int EFF_W       = 31;
	localparam int GAIN_W      = 16;
	localparam int GAIN_SHIFT  = 15;
	localparam int Q9_SHIFT    = 9;
	localparam int CURR_SHIFT  = 3;
	localparam int IFAC_W      = SHOWN_W - CURR_SHIFT;
	localparam int PROD_W      = SHOWN_W + IFAC_W;
	localparam int DVD_W       = POWER_W + Q9_SHIFT;
	localparam int DVS_W       = THEO_W;
	localparam int HUNDRED_W   = 7;
	localparam int EFF_FULL_W  = DVD_W + HUNDRED_W;
	localparam int OUT_FIELD_W = 3 * SHOWN_W + POWER_W + EFF_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PV = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PC = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_BV = 2'd2;

	// Offsets and scales
	localparam logic [SHOWN_W-1:0]    VOLT_OFFSET = 16'd102; // 0.20 in Q9
	localparam logic [SHOWN_W-1:0]    CURR_OFFSET = 16'd122; // 0.03 in Q12
	localparam logic [HUNDRED_W-1:0]  HUNDRED     = 7'd100;  // 100.0 Q9 >> 9
	localparam logic [SHOWN_W-1:0]    SHOWN_MAX   = 16'hFFFF;
	localparam logic [EFF_W-1:0]      EFF_MAX     = 31'h7FFF_FFFF;

	typedef logic [SHOWN_W-1:0] shown_t;

endpackage

>>> sv/solar_panel_boxcar_dashboard_unit.sv
// Top level of the solar panel boxcar dashboard: sequencer, gains, output register.
//
// Use:
//  - Input stream (s_tvalid/s_tready/s_tdata) carries one timer tick per
//    transaction: three ADC samples and the theoretical panel power.
//  - Output stream (m_tvalid/m_tready/m_tdata) returns one result per tick:
//    three averaged, gain-scaled values, panel power and tracking efficiency.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the three
//    Q15 gains; cfg_ready is always high, unknown indexes are dropped.
// Flow:
//  - One tick at a time. From input transaction to m_tvalid the tick passes
//    the history read-modify-write, the shared gain multiplier, power, the
//    bit-serial efficiency divider, then the efficiency and output registers.
//    The 29-bit divider is skipped when theoretical power is zero.
//  - s_tready is high again once the result sits in the output register, so
//    a new tick is taken while the receiver has not yet taken the last result.
//    A held result only blocks the next one from leaving.
// Reset: histories read as zero (per-entry valid bits), sums, gains and ring
//  position clear, no result pending.
module solar_panel_boxcar_dashboard_unit #(
	parameter int HISTORY_DEPTH = 8,
	parameter int SAMPLE_BITS   = 12,
	parameter int IN_TDATA_W    = ((3 * SAMPLE_BITS + 20 + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// pv_sample, pc_sample, bv_sample (SAMPLE_BITS each), theoretical_power (20)
	input  logic [IN_TDATA_W-1:0]             s_tdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// shown_panel_voltage (16), shown_panel_current (16), shown_boost_voltage
	// (16), panel_power (20), tracking_efficiency (31), zero pad
	output logic [spbd_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [spbd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [spbd_pkg::GAIN_W-1:0]       cfg_data
);
	import spbd_pkg::*;

	localparam int SUM_W  = SAMPLE_BITS + $clog2(HISTORY_DEPTH);
	localparam int MUL_W  = SUM_W + GAIN_W + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HIST = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_POW  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_EFF  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]             state_q;
	logic [GAIN_W-1:0]      gain_q [3];
	logic [THEO_W-1:0]      theo_q;
	logic [1:0]             mul_cnt_q;
	shown_t                 shown_q [3];
	logic [POWER_W-1:0]     power_q;
	logic [EFF_W-1:0]       eff_q;
	logic [OUT_TDATA_W-1:0] out_q;
	logic                   out_valid_q;

	logic                   in_acc;
	logic                   hist_done;
	logic [SUM_W-1:0]       sum_pv;
	logic [SUM_W-1:0]       sum_pc;
	logic [SUM_W-1:0]       sum_bv;
	logic [SUM_W-1:0]       sum_sel;
	logic [MUL_W-1:0]       mul_full;
	logic [MUL_W-1:0]       mul_scaled;
	shown_t                 mul_sat;
	logic [SHOWN_W-1:0]     vfac;
	logic [SHOWN_W-1:0]     ifac_diff;
	logic [IFAC_W-1:0]      ifac;
	logic [PROD_W-1:0]      pow_prod;
	logic [POWER_W-1:0]     pow_comb;
	logic                   div_start;
	logic                   div_done;
	logic [DVD_W-1:0]       div_quo;
	logic [EFF_FULL_W-1:0]  eff_full;

	assign in_acc    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	spbd_hist #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.SAMPLE_BITS   (SAMPLE_BITS),
		.SUM_W         (SUM_W)
	) u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_acc),
		.pv_sample (s_tdata[SAMPLE_BITS-1:0]),
		.pc_sample (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.bv_sample (s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
		.sum_pv    (sum_pv),
		.sum_pc    (sum_pc),
		.sum_bv    (sum_bv),
		.done      (hist_done)
	);

	// shared gain multiplier, one channel per cycle
	always_comb begin
		case (mul_cnt_q)
			2'd0:    sum_sel = sum_pv;
			2'd1:    sum_sel = sum_pc;
			default: sum_sel = sum_bv;
		endcase
	end

	assign mul_full   = MUL_W'(sum_sel) * MUL_W'(gain_q[mul_cnt_q]);
	assign mul_scaled = mul_full >> GAIN_SHIFT;
	assign mul_sat    = (mul_scaled > MUL_W'(SHOWN_MAX)) ? SHOWN_MAX
		: mul_scaled[SHOWN_W-1:0];

	// power = (V - offset)+ * ((I - offset) >> 3)+ >> 9; always fits 20 bits
	assign vfac      = (shown_q[0] > VOLT_OFFSET) ? shown_q[0] - VOLT_OFFSET : '0;
	assign ifac_diff = (shown_q[1] > CURR_OFFSET) ? shown_q[1] - CURR_OFFSET : '0;
	assign ifac      = ifac_diff[SHOWN_W-1:CURR_SHIFT];
	assign pow_prod  = PROD_W'(vfac) * PROD_W'(ifac);
	assign pow_comb  = pow_prod[PROD_W-1:Q9_SHIFT];

	assign div_start = (state_q == ST_POW) && (theo_q != '0);

	spbd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({pow_comb, {Q9_SHIFT{1'b0}}}),
		.divisor  (theo_q),
		.quotient (div_quo),
		.done     (div_done)
	);

	// (q * 51200) >> 9 is exactly q * 100
	assign eff_full = EFF_FULL_W'(div_quo) * EFF_FULL_W'(HUNDRED);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < 3; g++) gain_q[g] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN_PV: gain_q[0] <= cfg_data;
				REG_GAIN_PC: gain_q[1] <= cfg_data;
				REG_GAIN_BV: gain_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			theo_q <= s_tdata[3*SAMPLE_BITS+THEO_W-1:3*SAMPLE_BITS];
		end
		if (state_q == ST_MUL) begin
			shown_q[mul_cnt_q] <= mul_sat;
		end
		if (state_q == ST_POW) begin
			power_q <= pow_comb;
		end
		if (state_q == ST_EFF) begin
			if (theo_q == '0) begin
				eff_q <= '0;
			end else if (|eff_full[EFF_FULL_W-1:EFF_W]) begin
				eff_q <= EFF_MAX;
			end else begin
				eff_q <= eff_full[EFF_W-1:0];
			end
		end
		if (state_q == ST_OUT && (!out_valid_q || m_tready)) begin
			out_q <= OUT_TDATA_W'({eff_q, power_q, shown_q[2], shown_q[1], shown_q[0]});
		end
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mul_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load wins over the drain of the previous result
			if (state_q == ST_OUT && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) state_q <= ST_HIST;
				end
				ST_HIST: begin
					mul_cnt_q <= '0;
					if (hist_done) state_q <= ST_MUL;
				end
				ST_MUL: begin
					mul_cnt_q <= mul_cnt_q + 1'b1;
					if (mul_cnt_q == 2'd2) state_q <= ST_POW;
				end
				ST_POW: begin
					state_q <= (theo_q == '0) ? ST_EFF : ST_DIV;
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_EFF;
				end
				ST_EFF: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tdata  = out_q;
	assign m_tvalid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_hist_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		hist_done |-> state_q == ST_HIST)
		else $error("history done outside wait state");
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider done outside wait state");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("second tick taken while one is in flight");
`endif

endmodule

>>> sv/spbd_hist.sv
// History memory with running sums for the three sample channels.
module spbd_hist #(
	parameter int HISTORY_DEPTH = 8,
	parameter int SAMPLE_BITS   = 12,
	parameter int SUM_W         = SAMPLE_BITS + $clog2(HISTORY_DEPTH)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [SAMPLE_BITS-1:0]   pv_sample,
	input  logic [SAMPLE_BITS-1:0]   pc_sample,
	input  logic [SAMPLE_BITS-1:0]   bv_sample,
	output logic [SUM_W-1:0]         sum_pv,
	output logic [SUM_W-1:0]         sum_pc,
	output logic [SUM_W-1:0]         sum_bv,
	output logic                     done
);
	import spbd_pkg::*;

	localparam int PTR_W   = $clog2(HISTORY_DEPTH);
	localparam int ENTRY_W = 3 * SAMPLE_BITS;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

	logic [ENTRY_W-1:0]       mem [HISTORY_DEPTH];
	logic [ENTRY_W-1:0]       rd_q;
	logic [HISTORY_DEPTH-1:0] valid_q;
	logic [PTR_W-1:0]         ptr_q;
	logic [PTR_W-1:0]         ptr_nx;
	logic [ENTRY_W-1:0]       new_s1;
	logic                     pend_s1;
	logic                     old_valid_s1;
	logic                     done_q;
	logic [SUM_W-1:0]         sum_q [3];
	logic [ENTRY_W-1:0]       old_entry;

	assign ptr_nx    = (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
	assign old_entry = old_valid_s1 ? rd_q : '0;

	// memory: read at the next slot on start, write back in the following cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rd_q   <= mem[ptr_nx];
			new_s1 <= {bv_sample, pc_sample, pv_sample};
		end
		if (pend_s1) begin
			mem[ptr_q] <= new_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			valid_q      <= '0;
			pend_s1      <= 1'b0;
			old_valid_s1 <= 1'b0;
			done_q       <= 1'b0;
			for (int l = 0; l < 3; l++) sum_q[l] <= '0;
		end else begin
			done_q  <= pend_s1;
			pend_s1 <= start;
			if (start) begin
				ptr_q        <= ptr_nx;
				old_valid_s1 <= valid_q[ptr_nx];
			end
			if (pend_s1) begin
				valid_q[ptr_q] <= 1'b1;
				// sum += new - old, per lane
				for (int l = 0; l < 3; l++) begin
					sum_q[l] <= sum_q[l]
						+ SUM_W'(new_s1[l*SAMPLE_BITS +: SAMPLE_BITS])
						- SUM_W'(old_entry[l*SAMPLE_BITS +: SAMPLE_BITS]);
				end
			end
		end
	end

	assign sum_pv = sum_q[0];
	assign sum_pc = sum_q[1];
	assign sum_bv = sum_q[2];
	assign done   = done_q;

`ifndef NO_ASSERTIONS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !pend_s1)
		else $error("history start while write-back pending");
	a_valid_set: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |=> valid_q[ptr_q])
		else $error("written entry not marked valid");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(pend_s1))
		else $error("done without a write-back");
`endif

endmodule

>>> sv/spbd_div.sv
// Restoring divider, one quotient bit per cycle.
module spbd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [spbd_pkg::DVD_W-1:0]  dividend,
	input  logic [spbd_pkg::DVS_W-1:0]  divisor,
	output logic [spbd_pkg::DVD_W-1:0]  quotient,
	output logic                        done
);
	import spbd_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   rem_sh;
	logic [DVS_W+1:0] diff;
	logic             ge;

	assign rem_sh = {rem_q, quo_q[DVD_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign ge     = !diff[DVS_W+1];

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the solar panel boxcar dashboard unit.
module testbench;
	import spbd_pkg::*;

	// Build of the block under test and the input stream packing that follows from it
	localparam int HIST_DEPTH = 8;
	localparam int SAMPLE_W   = 12;
	localparam int IN_W       = ((3 * SAMPLE_W + THEO_W + 7) / 8) * 8;

	// Run shape
	localparam int SEGMENTS          = 4;    // gain settings per idling phase
	localparam int TICKS_PER_SEGMENT = 129;  // 3 phases x 4 x 129 random ticks
	localparam int SETTLE_CYCLES     = 48;   // margin beyond the time a tick takes through the block
	localparam int STALL_LIMIT       = 4000; // quiet cycles before the run is declared hung
	localparam int SEND_IDLE [3]     = '{9, 86, 0};
	localparam int RECV_STALL [3]    = '{86, 9, 0};

	// Index three decodes to nothing; writes to it must leave every gain alone
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	localparam logic [POWER_W-1:0] POWER_MAX  = '1;
	localparam logic [63:0]        HUNDRED_Q9 = 64'(HUNDRED) << Q9_SHIFT;

	// One readout of the dashboard, as it leaves on m_tdata
	typedef struct packed {
		shown_t               volt;
		shown_t               curr;
		shown_t               boost;
		logic [POWER_W-1:0]   power;
		logic [EFF_W-1:0]     eff;
	} dash_t;

	// Readout fields whose value is typed into the table rather than predicted
	localparam logic [4:0] FIX_NONE  = 5'b00000;
	localparam logic [4:0] FIX_VOLT  = 5'b00001;
	localparam logic [4:0] FIX_CURR  = 5'b00010;
	localparam logic [4:0] FIX_BOOST = 5'b00100;
	localparam logic [4:0] FIX_POWER = 5'b01000;
	localparam logic [4:0] FIX_EFF   = 5'b10000;
	localparam logic [4:0] FIX_ALL   = 5'b11111;

	localparam dash_t DASH_ZERO = '0;
	localparam dash_t EFF_SAT   = '{volt: '0, curr: '0, boost: '0, power: '0, eff: EFF_MAX};

	typedef enum logic {ROW_TICK, ROW_GAIN} row_kind_t;

	typedef struct packed {
		row_kind_t               kind;
		logic [SAMPLE_W-1:0]     volt;
		logic [SAMPLE_W-1:0]     curr;
		logic [SAMPLE_W-1:0]     boost;
		logic [THEO_W-1:0]       theo;
		logic [CFG_IDX_W-1:0]    reg_idx;
		logic [GAIN_W-1:0]       reg_val;
		logic [4:0]              fixed;
		dash_t                   known;
	} dash_row_t;

	// Directed part. History is tracked by hand: the first tick lands in slot 1.
	dash_row_t directed_rows [26] = '{
		// zero gains straight after reset: every readout field is zero
		'{ROW_TICK, 12'h000, 12'h000, 12'h000, 20'h00000, REG_GAIN_PV, 16'h0000, FIX_ALL, DASH_ZERO},
		'{ROW_TICK, 12'hFFF, 12'hFFF, 12'hFFF, 20'hFFFFF, REG_GAIN_PV, 16'h0000, FIX_ALL, DASH_ZERO},
		'{ROW_TICK, 12'h800, 12'h7FF, 12'h555, 20'h00001, REG_GAIN_PV, 16'h0000, FIX_ALL, DASH_ZERO},
		// full-scale gains, then a write to the unused index
		'{ROW_GAIN, 12'h000, 12'h000, 12'h000, 20'h00000, REG_GAIN_PV, 16'hFFFF, FIX_NONE, DASH_ZERO},
		'{ROW_GAIN, 12'h000, 12'h000, 12'h000, 20'h00000, REG_GAIN_PC, 16'hFFFF, FIX_NONE, DASH_ZERO},
		'{ROW_GAIN, 12'h000, 12'h000, 12'h000, 20'h00000, REG_GAIN_BV, 16'hFFFF, FIX_NONE, DASH_ZERO},
		'{ROW_GAIN, 12'h000, 12'h000, 12'h000, 20'h00000, REG_NONE,    16'h1234, FIX_NONE, DASH_ZERO},
		// fill the histories with full-scale samples against the smallest theoretical power
		'{ROW_TICK, 12'hFFF, 12'hFFF, 12'hFFF, 20'h00001, REG_GAIN_PV, 16'h0000, FIX_NONE, DASH_ZERO},
		'{ROW_TICK, 12'hFFF, 12'hFFF, 12'hFFF, 20'h00001, REG_GAIN_PV, 16'h0000, FIX_NONE, DASH_ZERO},
		'{ROW_TICK, 12'hFFF, 12'hFFF, 12'hFFF, 20'h00001, REG_GAIN_PV, 16'h0000, FIX_NONE, DASH_ZERO},
		'{ROW_TICK, 12'hFFF, 12'hFFF, 12'hFFF, 20'h00001, REG_GAIN_PV, 16'h0000, FIX_NONE, DASH_ZERO},
		'{ROW_TICK, 12'hFFF, 12'hFFF, 12'hFFF, 20'h00001, REG_GAIN_PV, 16'h0000, FIX_NONE, DASH_ZERO},
		'{ROW_TICK, 12'hFFF, 12'hFFF, 12'hFFF, 20'h00001, REG_GAIN_PV, 16'h0000, FIX_NONE, DASH_ZERO},
		'{ROW_TICK, 12'hFFF, 12'hFFF, 12'hFFF, 20'h00001, REG_GAIN_PV, 16'h0000, FIX_NONE, DASH_ZERO},
		// histories now all full scale: efficiency pinned at its ceiling
		'{ROW_TICK, 12'hFFF, 12'hFFF, 12'hFFF, 20'h00001, REG_GAIN_PV, 16'h0000, FIX_EFF, EFF_SAT},
		'{ROW_TICK, 12'hFFF, 12'hFFF, 12'hFFF, 20'hFFFFF, REG_GAIN_PV, 16'h0000, FIX_NONE, DASH_ZERO},
		// no theoretical power: efficiency off
		'{ROW_TICK, 12'hFFF, 12'hFFF, 12'hFFF, 20'h00000, REG_GAIN_PV, 16'h0000, FIX_EFF, DASH_ZERO},
		// tiny current gain keeps shown current under its offset: no power
		'{ROW_GAIN, 12'h000, 12'h000, 12'h000, 20'h00000, REG_GAIN_PC, 16'h0001, FIX_NONE, DASH_ZERO},
		'{ROW_TICK, 12'hABC, 12'h123, 12'hFFF, 20'h00400, REG_GAIN_PV, 16'h0000,
			FIX_CURR | FIX_POWER | FIX_EFF, DASH_ZERO},
		// zero voltage gain: voltage under its offset, no power either
		'{ROW_GAIN, 12'h000, 12'h000, 12'h000, 20'h00000, REG_GAIN_PC, 16'hFFFF, FIX_NONE, DASH_ZERO},
		'{ROW_GAIN, 12'h000, 12'h000, 12'h000, 20'h00000, REG_GAIN_PV, 16'h0000, FIX_NONE, DASH_ZERO},
		'{ROW_TICK, 12'h0F0, 12'hFFF, 12'h000, 20'h00400, REG_GAIN_PV, 16'h0000,
			FIX_VOLT | FIX_POWER | FIX_EFF, DASH_ZERO},
		// unity voltage gain, histories drained towards mid-scale values
		'{ROW_GAIN, 12'h000, 12'h000, 12'h000, 20'h00000, REG_GAIN_PV, 16'h8000, FIX_NONE, DASH_ZERO},
		'{ROW_TICK, 12'h000, 12'h000, 12'h000, 20'h003FF, REG_GAIN_PV, 16'h0000, FIX_NONE, DASH_ZERO},
		'{ROW_TICK, 12'h000, 12'h000, 12'h000, 20'h80000, REG_GAIN_PV, 16'h0000, FIX_NONE, DASH_ZERO},
		'{ROW_TICK, 12'h7FF, 12'h800, 12'hAAA, 20'h7FFFF, REG_GAIN_PV, 16'h0000, FIX_NONE, DASH_ZERO}
	};

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic [IN_W-1:0]        s_tdata   = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [GAIN_W-1:0]      cfg_data  = '0;

	// Idling rates of the current phase, in percent of cycles
	int send_idle_pct  = SEND_IDLE[0];
	int recv_stall_pct = RECV_STALL[0];
	int mismatches     = 0;

	// Own copy of the dashboard state: gains, ring pointer and the three histories
	logic [GAIN_W-1:0]             gain_volt  = '0;
	logic [GAIN_W-1:0]             gain_curr  = '0;
	logic [GAIN_W-1:0]             gain_boost = '0;
	logic [$clog2(HIST_DEPTH)-1:0] ring_pos   = '0;
	logic [SAMPLE_W-1:0]           volt_hist  [HIST_DEPTH] = '{default: '0};
	logic [SAMPLE_W-1:0]           curr_hist  [HIST_DEPTH] = '{default: '0};
	logic [SAMPLE_W-1:0]           boost_hist [HIST_DEPTH] = '{default: '0};

	// Readouts still owed by the block, oldest first
	dash_t awaited_readouts [$];

	solar_panel_boxcar_dashboard_unit #(
		.HISTORY_DEPTH(HIST_DEPTH),
		.SAMPLE_BITS  (SAMPLE_W)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),    // volt, curr, boost sample (12 each), theoretical power (20)
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),    // volt, curr, boost (16 each), power (20), efficiency (31), pad
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Q15 scaling of a boxcar sum, clipped to the display width
	function automatic shown_t boxcar_scaled(input logic [63:0] total,
			input logic [GAIN_W-1:0] gain);
		logic [63:0] v;
		v = (total * 64'(gain)) >> GAIN_SHIFT;
		return (v > 64'(SHOWN_MAX)) ? SHOWN_MAX : shown_t'(v);
	endfunction

	// Advances the dashboard by one tick and returns the readout it should produce
	function automatic dash_t dashboard_after_tick(input logic [SAMPLE_W-1:0] volt, curr, boost,
			input logic [THEO_W-1:0] theo);
		dash_t       r;
		logic [63:0] vsum, csum, bsum, vfac, ifac, power, eff;
		vsum = '0;
		csum = '0;
		bsum = '0;
		// pointer moves first, so the tick after reset lands in slot 1
		ring_pos = (ring_pos == HIST_DEPTH - 1) ? '0 : ring_pos + 1'b1;
		volt_hist[ring_pos]  = volt;
		curr_hist[ring_pos]  = curr;
		boost_hist[ring_pos] = boost;
		for (int k = 0; k < HIST_DEPTH; k++) begin
			vsum += 64'(volt_hist[k]);
			csum += 64'(curr_hist[k]);
			bsum += 64'(boost_hist[k]);
		end
		r.volt  = boxcar_scaled(vsum, gain_volt);
		r.curr  = boxcar_scaled(csum, gain_curr);
		r.boost = boxcar_scaled(bsum, gain_boost);

		// offset-clamped factors; the current one drops to Q9 as well
		vfac = (r.volt > VOLT_OFFSET) ? 64'(r.volt - VOLT_OFFSET) : '0;
		ifac = (r.curr > CURR_OFFSET) ? 64'((r.curr - CURR_OFFSET) >> CURR_SHIFT) : '0;
		power = (vfac * ifac) >> Q9_SHIFT;
		if (power > 64'(POWER_MAX))
			power = 64'(POWER_MAX);
		r.power = power[POWER_W-1:0];

		if (theo != '0) begin
			eff = (((power << Q9_SHIFT) / 64'(theo)) * HUNDRED_Q9) >> Q9_SHIFT;
			if (eff > 64'(EFF_MAX))
				eff = 64'(EFF_MAX);
		end else begin
			eff = '0;
		end
		r.eff = eff[EFF_W-1:0];
		return r;
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return SAMPLE_W'($urandom_range((1 << SAMPLE_W) - 1));
		endcase
	endfunction

	// Mostly spread over the range, with zero, one, small and full scale mixed in
	function automatic logic [THEO_W-1:0] pick_theo();
		case ($urandom_range(11))
			0: return '0;
			1: return THEO_W'(1);
			2: return '1;
			3: return THEO_W'($urandom_range(255));
			default: return THEO_W'($urandom_range((1 << THEO_W) - 1));
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return 16'h8000;
			default: return GAIN_W'($urandom_range((1 << GAIN_W) - 1));
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want, got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Offers one tick, after a random gap, and books its readout once accepted.
	// Fields flagged in fixed take the typed-in value instead of the prediction.
	task automatic send_tick(input logic [SAMPLE_W-1:0] volt, curr, boost,
			input logic [THEO_W-1:0] theo, input logic [4:0] fixed, input dash_t known);
		dash_t readout;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {theo, boost, curr, volt};
		do @(posedge clk); while (!s_tready);
		readout = dashboard_after_tick(volt, curr, boost, theo);
		if (fixed & FIX_VOLT)
			readout.volt = known.volt;
		if (fixed & FIX_CURR)
			readout.curr = known.curr;
		if (fixed & FIX_BOOST)
			readout.boost = known.boost;
		if (fixed & FIX_POWER)
			readout.power = known.power;
		if (fixed & FIX_EFF)
			readout.eff = known.eff;
		awaited_readouts.push_back(readout);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_GAIN_PV: gain_volt  = val;
			REG_GAIN_PC: gain_curr  = val;
			REG_GAIN_BV: gain_boost = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stops offering ticks and holds off until the block has nothing left in flight
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (awaited_readouts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receiver back-pressure
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Readout checker: every output transaction against the oldest booked readout
	always @(posedge clk) begin
		dash_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_readouts.size() == 0) begin
				$display("%0t: readout with none awaited, expected nothing, actual %h",
					$time, m_tdata);
				mismatches++;
			end else begin
				want = awaited_readouts.pop_front();
				check_field("shown_panel_voltage", 64'(want.volt), 64'(m_tdata[SHOWN_W-1:0]));
				check_field("shown_panel_current", 64'(want.curr),
					64'(m_tdata[2*SHOWN_W-1:SHOWN_W]));
				check_field("shown_boost_voltage", 64'(want.boost),
					64'(m_tdata[3*SHOWN_W-1:2*SHOWN_W]));
				check_field("panel_power", 64'(want.power),
					64'(m_tdata[3*SHOWN_W+POWER_W-1:3*SHOWN_W]));
				check_field("tracking_efficiency", 64'(want.eff),
					64'(m_tdata[OUT_FIELD_W-1:3*SHOWN_W+POWER_W]));
				check_field("tdata padding", '0, 64'(m_tdata[OUT_TDATA_W-1:OUT_FIELD_W]));
			end
		end
	end

	// Hang detector: too long without any transaction on any channel
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, under the first phase's idling
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_GAIN) begin
				wait_idle();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
			end else begin
				send_tick(directed_rows[i].volt, directed_rows[i].curr, directed_rows[i].boost,
					directed_rows[i].theo, directed_rows[i].fixed, directed_rows[i].known);
			end
		end

		// random ticks: three idling phases, fresh gains at each segment boundary
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct  = SEND_IDLE[phase];
			recv_stall_pct = RECV_STALL[phase];
			for (int seg = 0; seg < SEGMENTS; seg++) begin
				wait_idle();
				write_reg(REG_GAIN_PV, pick_gain());
				write_reg(REG_GAIN_PC, pick_gain());
				write_reg(REG_GAIN_BV, pick_gain());
				if ($urandom_range(3) == 0)
					write_reg(REG_NONE, GAIN_W'($urandom_range((1 << GAIN_W) - 1)));
				for (int n = 0; n < TICKS_PER_SEGMENT; n++)
					send_tick(pick_sample(), pick_sample(), pick_sample(), pick_theo(),
						FIX_NONE, DASH_ZERO);
			end
		end

		wait_idle();
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
